// ===== rtl/core/mexp_pkg.sv =====
// Shared constant for the modular exponentiation unit.
`timescale 1ns / 1ps

package mexp_pkg;

   localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

endpackage : mexp_pkg

// ===== rtl/core/mexp_if.sv =====
// Request and response stream interfaces of the modular exponentiation unit.
`timescale 1ns / 1ps

interface mexp_req_if #(
   parameter int WIDTH = 31
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] base;
   logic [WIDTH-1:0] exponent;

   modport source (output valid, output base, output exponent, input ready);
   modport sink   (input valid, input base, input exponent, output ready);
endinterface : mexp_req_if

interface mexp_rsp_if #(
   parameter int WIDTH = 31
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] power;

   modport source (output valid, output power, input ready);
   modport sink   (input valid, input power, output ready);
endinterface : mexp_rsp_if

// ===== rtl/core/modular_exponentiation_unit.sv =====
// Modular exponentiation by right-to-left square-and-multiply on a bit-serial modular multiplier.
//
//   channel  direction  beat contents
//   req_if   in         base, exponent
//   rsp_if   out        power = base ** exponent mod modulus
//   csr      in         modulus (write only)
//
// One beat at a time: the base is first reduced, then each exponent bit up to the highest set
// one takes a square, preceded by a multiply into the accumulator when the bit is set.
// The shared multiplier retires one multiplier bit per cycle.
// Reset is synchronous; modulus returns to 1000000007.
// A finished result waits in the output register while the next beat is taken.
`timescale 1ns / 1ps

module modular_exponentiation_unit
   import mexp_pkg::*;
#(
   parameter int OPERAND_WIDTH = 31
) (
   input  logic                     clock,
   input  logic                     reset,
   mexp_req_if.sink                 req_if,
   mexp_rsp_if.source               rsp_if,
   input  logic                     csr_write_en,
   input  logic [OPERAND_WIDTH-1:0] csr_write_data
);

   localparam int W  = OPERAND_WIDTH;
   localparam int CW = $clog2(W + 1);
   localparam logic [W-1:0]  ONE     = {{(W-1){1'b0}}, 1'b1};
   localparam logic [CW-1:0] CNT_ONE = {{(CW-1){1'b0}}, 1'b1};
   localparam logic [CW-1:0] CNT_W   = CW'(W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL_ACC,
      ST_MUL_SQ,
      ST_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [W-1:0]  modulus_ff, modulus_in;
   logic [W-1:0]  mul_a_ff, mul_a_in;
   logic [W-1:0]  mul_b_ff, mul_b_in;
   logic [W-1:0]  r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  sq_ff, sq_in;
   logic [W-1:0]  exp_ff, exp_in;
   logic [W-1:0]  power_ff, power_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [W-1:0]  one_mod;
   logic [W-1:0]  addend;
   logic [W+1:0]  sum;
   logic [W+1:0]  mod1;
   logic [W+1:0]  mod2;
   logic [W+1:0]  reduced;
   logic [W-1:0]  r_step;
   logic          mul_last;

   assign one_mod  = (modulus_ff == ONE) ? '0 : ONE;
   assign addend   = mul_b_ff[W-1] ? mul_a_ff : '0;
   assign sum      = {1'b0, r_ff, 1'b0} + {2'b00, addend};
   assign mod1     = {2'b00, modulus_ff};
   assign mod2     = {1'b0, modulus_ff, 1'b0};
   assign mul_last = (cnt_ff == CNT_ONE);

   always_comb begin
      if (sum >= mod2) begin
         reduced = sum - mod2;
      end else if (sum >= mod1) begin
         reduced = sum - mod1;
      end else begin
         reduced = sum;
      end
   end

   assign r_step = reduced[W-1:0];

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.power = power_ff;

   always_comb begin
      logic         dispatch;
      logic [W-1:0] d_exp;
      logic [W-1:0] d_sq;
      logic [W-1:0] d_acc;

      dispatch     = 1'b0;
      d_exp        = exp_ff;
      d_sq         = sq_ff;
      d_acc        = acc_ff;
      state_in     = state_ff;
      modulus_in   = csr_write_en ? csr_write_data : modulus_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = {mul_b_ff[W-2:0], 1'b0};
      r_in         = r_step;
      cnt_in       = cnt_ff - CNT_ONE;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      exp_in       = exp_ff;
      power_in     = power_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      case (state_ff)
         ST_IDLE: begin
            mul_b_in = mul_b_ff;
            r_in     = r_ff;
            cnt_in   = cnt_ff;
            if (req_if.valid) begin
               exp_in   = req_if.exponent;
               acc_in   = one_mod;
               mul_a_in = one_mod;
               mul_b_in = req_if.base;
               r_in     = '0;
               cnt_in   = CNT_W;
               if (modulus_ff == '0) begin
                  acc_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_last) begin
               sq_in    = r_step;
               dispatch = 1'b1;
               d_exp    = exp_ff;
               d_sq     = r_step;
               d_acc    = acc_ff;
            end
         end
         ST_MUL_ACC: begin
            if (mul_last) begin
               acc_in   = r_step;
               mul_a_in = sq_ff;
               mul_b_in = sq_ff;
               r_in     = '0;
               cnt_in   = CNT_W;
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_SQ: begin
            if (mul_last) begin
               sq_in    = r_step;
               exp_in   = exp_ff >> 1;
               dispatch = 1'b1;
               d_exp    = exp_ff >> 1;
               d_sq     = r_step;
               d_acc    = acc_ff;
            end
         end
         ST_FINISH: begin
            mul_b_in = mul_b_ff;
            r_in     = r_ff;
            cnt_in   = cnt_ff;
            if (!rsp_valid_ff || rsp_if.ready) begin
               power_in     = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (dispatch) begin
         r_in   = '0;
         cnt_in = CNT_W;
         if (d_exp == '0) begin
            state_in = ST_FINISH;
         end else if (d_exp[0]) begin
            mul_a_in = d_sq;
            mul_b_in = d_acc;
            state_in = ST_MUL_ACC;
         end else begin
            mul_a_in = d_sq;
            mul_b_in = d_sq;
            state_in = ST_MUL_SQ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MODULUS_RESET[W-1:0];
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
         cnt_ff       <= cnt_in;
      end
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      r_ff     <= r_in;
      acc_ff   <= acc_in;
      sq_ff    <= sq_in;
      exp_ff   <= exp_in;
      power_ff <= power_in;
   end

`ifndef ASSERT_OFF
   logic mul_busy;
   assign mul_busy = (state_ff == ST_REDUCE) || (state_ff == ST_MUL_ACC) ||
                     (state_ff == ST_MUL_SQ);

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> state_ff != ST_IDLE)
      else $error("accepted beat did not start work");

   a_partial_reduced: assert property (@(posedge clock) disable iff (reset)
      mul_busy |-> r_ff < modulus_ff)
      else $error("partial product not reduced");

   a_multiplicand_reduced: assert property (@(posedge clock) disable iff (reset)
      mul_busy |-> mul_a_ff < modulus_ff)
      else $error("multiplicand not reduced");

   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      mul_busy |-> cnt_ff != '0)
      else $error("multiplier count ran out");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      mul_busy |-> acc_ff < modulus_ff)
      else $error("accumulator not reduced");
`endif

endmodule : modular_exponentiation_unit

// ===== bench/tb.sv =====
// Self-checking testbench for the modular exponentiation unit: directed table, then random phases.
`timescale 1ns / 1ps

module tb
   import mexp_pkg::*;
();

   localparam int W = 31;
   localparam logic [W-1:0] MAX_OPERAND = {W{1'b1}};
   localparam int PHASES = 7;
   localparam int ITEMS_PER_PHASE = 38;
   localparam int LONG_HOLD = 3000;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 2048;
   localparam int DIRECTED_COUNT = 24;

   typedef struct packed {
      logic [W-1:0] modulus;
      logic [W-1:0] base;
      logic [W-1:0] exponent;
      bit           typed;
      logic [W-1:0] power;
   } vector_type;

   bit   clock = 1'b0;
   logic reset = 1'b1;
   logic         csr_write_en;
   logic [W-1:0] csr_write_data;

   mexp_req_if #(.WIDTH(W)) req ();
   mexp_rsp_if #(.WIDTH(W)) rsp ();

   modular_exponentiation_unit #(.OPERAND_WIDTH(W)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req),
      .rsp_if         (rsp),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   logic [W-1:0] pending_powers[$];
   logic [W-1:0] cur_modulus = MODULUS_RESET[W-1:0];
   int           error_count = 0;
   int           stall_cycles = 0;
   bit           hold_off_pending = 1'b0;
   bit           calm = 1'b0;

   vector_type directed_vec [DIRECTED_COUNT] = '{
      '{31'd1000000007, 31'h0,        31'h0,        1'b1, 31'd1},
      '{31'd1000000007, 31'd2,        31'd10,       1'b1, 31'd1024},
      '{31'd1000000007, 31'h7FFFFFFF, 31'h0,        1'b1, 31'd1},
      '{31'd1000000007, 31'h7FFFFFFF, 31'd1,        1'b1, 31'd147483633},
      '{31'd1000000007, 31'h0,        31'h7FFFFFFF, 1'b1, 31'd0},
      '{31'd1000000007, 31'd1,        31'h7FFFFFFF, 1'b1, 31'd1},
      '{31'd1000000007, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0, 31'd0},
      '{31'd1000000007, 31'd1000000006, 31'd2,      1'b1, 31'd1},
      '{31'd1000000007, 31'd1000000007, 31'd5,      1'b1, 31'd0},
      '{31'h7FFFFFFF,   31'h7FFFFFFF, 31'd3,        1'b1, 31'd0},
      '{31'h7FFFFFFF,   31'h7FFFFFFE, 31'h7FFFFFFF, 1'b1, 31'h7FFFFFFE},
      '{31'h7FFFFFFF,   31'd3,        31'h7FFFFFFE, 1'b1, 31'd1},
      '{31'h7FFFFFFF,   31'd12345,    31'h55555555, 1'b0, 31'd0},
      '{31'd2,          31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 31'd1},
      '{31'd2,          31'h7FFFFFFE, 31'd1,        1'b1, 31'd0},
      '{31'd2,          31'd5,        31'd0,        1'b1, 31'd1},
      '{31'h40000000,   31'd2,        31'd30,       1'b1, 31'd0},
      '{31'h40000000,   31'd2,        31'd29,       1'b1, 31'h20000000},
      '{31'h40000000,   31'd3,        31'h2AAAAAAA, 1'b0, 31'd0},
      '{31'd1,          31'd5,        31'd0,        1'b1, 31'd0},
      '{31'd1,          31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 31'd0},
      '{31'd0,          31'd5,        31'd0,        1'b1, 31'd0},
      '{31'd0,          31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 31'd0},
      '{31'd1000000007, 31'h2AAAAAAA, 31'h55555555, 1'b0, 31'd0}
   };

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [W-1:0] predict_power(logic [W-1:0] m, logic [W-1:0] b,
                                                   logic [W-1:0] e);
      logic [63:0]  acc;
      logic [63:0]  sq;
      logic [W-1:0] rest;
      if (m == '0) begin
         return '0;
      end
      acc  = 64'd1 % 64'(m);
      sq   = 64'(b) % 64'(m);
      rest = e;
      while (rest != '0) begin
         if (rest[0]) begin
            acc = (acc * sq) % 64'(m);
         end
         sq   = (sq * sq) % 64'(m);
         rest = rest >> 1;
      end
      return acc[W-1:0];
   endfunction

   function automatic logic [W-1:0] pick_modulus(int phase);
      logic [W-1:0] m;
      case (phase)
         0: m = 31'd1000000007;
         1: m = W'($urandom_range(2, 64));
         3: m = MAX_OPERAND;
         4: m = W'($urandom & MAX_OPERAND) & ~31'd1;
         5: m = W'($urandom & MAX_OPERAND);
         default: m = W'($urandom & MAX_OPERAND) | 31'd1;
      endcase
      if (m < 31'd2) begin
         m = 31'd3;
      end
      return m;
   endfunction

   function automatic logic [W-1:0] pick_base();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return MAX_OPERAND;
         2: return cur_modulus - 31'd1;
         3: return cur_modulus + 31'($urandom_range(0, 3));
         default: return W'($urandom & MAX_OPERAND);
      endcase
   endfunction

   function automatic logic [W-1:0] pick_exponent();
      int len;
      case ($urandom_range(0, 7))
         0: return W'($urandom & MAX_OPERAND);
         1: return W'($urandom_range(0, 3));
         default: begin
            len = $urandom_range(1, 20);
            return W'($urandom & ((32'd1 << len) - 32'd1));
         end
      endcase
   endfunction

   task automatic flag_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic send_item(logic [W-1:0] b, logic [W-1:0] e, bit typed, logic [W-1:0] power);
      @(negedge clock);
      req.valid    <= 1'b1;
      req.base     <= b;
      req.exponent <= e;
      do @(posedge clock); while (req.ready !== 1'b1);
      pending_powers = {pending_powers, (typed ? power : predict_power(cur_modulus, b, e))};
   endtask

   task automatic idle_req(int cycles);
      @(negedge clock);
      req.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_powers.size() != 0) @(posedge clock);
   endtask

   task automatic set_modulus(logic [W-1:0] m);
      drain();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= m;
      cur_modulus = m;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      vector_type row;
      int         phase;
      int         n;
      req.valid      = 1'b0;
      req.base       = '0;
      req.exponent   = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_COUNT; n++) begin
         row = directed_vec[n];
         if (row.modulus != cur_modulus) begin
            set_modulus(row.modulus);
         end
         send_item(row.base, row.exponent, row.typed, row.power);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         set_modulus(pick_modulus(phase));
         if (phase == 1) begin
            hold_off_pending = 1'b1;
         end
         if (phase == PHASES - 1) begin
            calm = 1'b1;
         end
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
               drain();
            end
            if (!calm && $urandom_range(0, 3) == 0) begin
               idle_req($urandom_range(1, 18));
            end
            send_item(pick_base(), pick_exponent(), 1'b0, '0);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_powers.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      int gap;
      gap = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            rsp.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_off_pending = 1'b0;
         end else if (gap > 0) begin
            rsp.ready <= 1'b0;
            gap--;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp.ready <= 1'b0;
            gap = $urandom_range(1, 18) - 1;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      logic [W-1:0] want;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (pending_powers.size() == 0) begin
            flag_mismatch("power beat with nothing outstanding", rsp.power, '0);
         end else begin
            want = pending_powers.pop_front();
            if (rsp.power !== want) begin
               flag_mismatch("power", rsp.power, want);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid === 1'b1 && req.ready === 1'b1)
                || (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

endmodule : tb
